[rtl/coons_patch_pole_grid_unit_defines.svh]
// assertion macros for the coons pole grid unit
// no dependencies; taken in by the top level only
`ifndef COONS_PATCH_POLE_GRID_UNIT_DEFINES_SVH
`define COONS_PATCH_POLE_GRID_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define CPPG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cppg check failed");

// next-cycle implication, quiet while reset is high
`define CPPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cppg check failed");

`endif

[rtl/cppg_pkg.sv]
// shared types, constants and codes for the coons pole grid unit
// no dependencies; used by every module of the block but cppg_ram
package cppg_pkg;

  localparam int MAX_POLES = 64;
  localparam int IDX_W     = $clog2(MAX_POLES);
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 48;
  localparam int WGT_W     = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SIDE_W    = 2;
  localparam int N_SIDES   = 4;
  localparam int N_COORD   = 3;
  localparam int N_LANES   = N_COORD + 1;

  // blend arithmetic widths
  localparam int COEF_W  = 2 * IDX_W;
  localparam int PROD_W  = COORD_W + COEF_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int WPROD_W = WGT_W + COEF_W;
  localparam int WSUM_W  = WPROD_W + 2;

  // divider
  localparam int NUM_W      = 64;
  localparam int REM_W      = COEF_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  localparam int BLEND_STAGES = 5;
  localparam int N_STAGES     = 2 + BLEND_STAGES + DIV_STAGES;

  // lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // sides
  localparam logic [SIDE_W-1:0] SIDE_FIRST_ROW = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_LAST_COL  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_LAST_ROW  = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_FIRST_COL = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLES_U  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLES_V  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIONAL = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [WGT_W-1:0]          wgt_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [COEF_W-1:0]         coef_t;

  localparam wgt_t WGT_ONE = wgt_t'(1) << FRAC_BITS;
  localparam wgt_t WGT_MAX = '1;
  localparam logic [NUM_W-1:0] COORD_POS_MAX = (NUM_W'(1) << (COORD_W - 1)) - NUM_W'(1);
  localparam logic [NUM_W-1:0] COORD_NEG_MAX = NUM_W'(1) << (COORD_W - 1);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    wgt_t   w;
  } pole_t;

  typedef struct packed {
    logic                      on_edge;
    logic [SIDE_W-1:0]         edge_side;
    coef_t [N_SIDES-1:0]       rule_k;
    coef_t [N_SIDES-1:0]       corner_k;
    coef_t                     den;
  } geom_t;

  typedef struct packed {
    logic                                on_edge;
    pole_t                               edge_pole;
    coef_t                               den;
    logic [N_COORD-1:0]                  neg;
    logic [N_LANES-1:0][NUM_W-1:0]       work;
    logic [N_LANES-1:0][REM_W-1:0]       rem;
  } div_word_t;

endpackage

[rtl/cppg_ram.sv]
// generic ram, one write port and two registered read ports
// no dependencies
module cppg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/cppg_blend.sv]
// blend stages: weighted products, adder tree, sign and rounding offset
// depends on cppg_pkg
module cppg_blend (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [cppg_pkg::BLEND_STAGES-1:0]        en,
  input  logic                                     din_valid,
  input  cppg_pkg::geom_t                          geom,
  input  cppg_pkg::pole_t [cppg_pkg::N_SIDES-1:0]  pa,
  input  cppg_pkg::pole_t [cppg_pkg::N_SIDES-1:0]  pb,
  output logic [cppg_pkg::BLEND_STAGES-1:0]        vout,
  output cppg_pkg::div_word_t                      dout
);
  import cppg_pkg::*;

  function automatic coord_t coord_of(pole_t p, int lane);
    case (lane)
      LANE_X:  return p.x;
      LANE_Y:  return p.y;
      default: return p.z;
    endcase
  endfunction

  // products
  logic signed [PROD_W-1:0] pr2 [N_COORD][N_SIDES];
  logic signed [PROD_W-1:0] pc2 [N_COORD][N_SIDES];
  logic [WPROD_W-1:0]       pw2 [N_SIDES];
  // pair sums
  logic signed [SUM_W-1:0]  ra3 [N_COORD];
  logic signed [SUM_W-1:0]  rb3 [N_COORD];
  logic signed [SUM_W-1:0]  ca3 [N_COORD];
  logic signed [SUM_W-1:0]  cb3 [N_COORD];
  logic [WSUM_W-1:0]        wa3, wb3;
  // ruled and corner totals
  logic signed [SUM_W-1:0]  r4 [N_COORD];
  logic signed [SUM_W-1:0]  c4 [N_COORD];
  logic [WSUM_W-1:0]        w4;
  // signed numerators
  logic signed [SUM_W-1:0]  s5 [N_COORD];
  logic [WSUM_W-1:0]        wn5;

  logic  [BLEND_STAGES-2:0] e_q;
  pole_t                    ep_q [BLEND_STAGES-1];
  coef_t                    den_q [BLEND_STAGES-1];

  logic [NUM_W-1:0]         se [N_COORD];
  logic [NUM_W-1:0]         half;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= '0;
    end else begin
      if (en[0]) begin
        vout[0] <= din_valid;
      end
      for (int k = 1; k < BLEND_STAGES; k++) begin
        if (en[k]) begin
          vout[k] <= vout[k-1];
        end
      end
    end
  end

  // sideband
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_q[0]   <= geom.on_edge;
      ep_q[0]  <= pa[geom.edge_side];
      den_q[0] <= geom.den;
    end
    for (int k = 1; k < BLEND_STAGES - 1; k++) begin
      if (en[k]) begin
        e_q[k]   <= e_q[k-1];
        ep_q[k]  <= ep_q[k-1];
        den_q[k] <= den_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < N_COORD; c++) begin
        for (int s = 0; s < N_SIDES; s++) begin
          pr2[c][s] <= PROD_W'(coord_of(pa[s], c))
                       * PROD_W'($signed({1'b0, geom.rule_k[s]}));
          pc2[c][s] <= PROD_W'(coord_of(pb[s], c))
                       * PROD_W'($signed({1'b0, geom.corner_k[s]}));
        end
      end
      for (int s = 0; s < N_SIDES; s++) begin
        pw2[s] <= WPROD_W'(pa[s].w) * WPROD_W'(geom.rule_k[s]);
      end
    end
    if (en[1]) begin
      for (int c = 0; c < N_COORD; c++) begin
        ra3[c] <= SUM_W'(pr2[c][0]) + SUM_W'(pr2[c][1]);
        rb3[c] <= SUM_W'(pr2[c][2]) + SUM_W'(pr2[c][3]);
        ca3[c] <= SUM_W'(pc2[c][0]) + SUM_W'(pc2[c][1]);
        cb3[c] <= SUM_W'(pc2[c][2]) + SUM_W'(pc2[c][3]);
      end
      wa3 <= WSUM_W'(pw2[0]) + WSUM_W'(pw2[1]);
      wb3 <= WSUM_W'(pw2[2]) + WSUM_W'(pw2[3]);
    end
    if (en[2]) begin
      for (int c = 0; c < N_COORD; c++) begin
        r4[c] <= ra3[c] + rb3[c];
        c4[c] <= ca3[c] + cb3[c];
      end
      w4 <= wa3 + wb3;
    end
    if (en[3]) begin
      for (int c = 0; c < N_COORD; c++) begin
        s5[c] <= r4[c] - c4[c];
      end
      wn5 <= w4 + WSUM_W'(den_q[2]);
    end
  end

  // magnitude plus half the divisor, ready for a round-half-away divide
  always_comb begin
    half = NUM_W'(den_q[3] >> 1);
    for (int c = 0; c < N_COORD; c++) begin
      se[c] = {{(NUM_W-SUM_W){s5[c][SUM_W-1]}}, s5[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dout.on_edge   <= e_q[3];
      dout.edge_pole <= ep_q[3];
      dout.den       <= den_q[3];
      dout.rem       <= '0;
      for (int c = 0; c < N_COORD; c++) begin
        dout.neg[c]  <= s5[c][SUM_W-1];
        dout.work[c] <= s5[c][SUM_W-1] ? (half - se[c]) : (se[c] + half);
      end
      dout.work[LANE_W] <= NUM_W'(wn5);
    end
  end

endmodule

[rtl/cppg_divider.sv]
// pipelined restoring divider, four quotient bits per stage on all lanes
// depends on cppg_pkg
module cppg_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [cppg_pkg::DIV_STAGES-1:0]      en,
  input  logic                                 din_valid,
  input  cppg_pkg::div_word_t                  din,
  output logic [cppg_pkg::DIV_STAGES-1:0]      vout,
  output cppg_pkg::div_word_t                  dout
);
  import cppg_pkg::*;

  function automatic div_word_t div_step(div_word_t a);
    div_word_t        r;
    logic [REM_W:0]   t;
    r = a;
    for (int l = 0; l < N_LANES; l++) begin
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {r.rem[l], r.work[l][NUM_W-1]};
        r.work[l] = {r.work[l][NUM_W-2:0], 1'b0};
        if (t >= {1'b0, r.den}) begin
          t = t - {1'b0, r.den};
          r.work[l][0] = 1'b1;
        end
        r.rem[l] = t[REM_W-1:0];
      end
    end
    return r;
  endfunction

  div_word_t stg    [DIV_STAGES];
  div_word_t stg_in [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_in;

  always_comb begin
    stg_in[0] = din;
    v_in[0]   = din_valid;
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_in[k] = stg[k-1];
      v_in[k]   = vout[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          vout[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        stg[k] <= div_step(stg_in[k]);
      end
    end
  end

  assign dout = stg[DIV_STAGES-1];

endmodule

[rtl/coons_patch_pole_grid_unit.sv]
// top level of the coons pole grid unit: config, boundary stores, pipeline control
// depends on cppg_pkg, cppg_ram, cppg_blend, cppg_divider and the defines header
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     command, side, side_index, in_x/y/z,
//                                               in_weight, grid_u, grid_v
//   out      source     out_valid / out_ready   pole_x/y/z, pole_weight
//   cfg      sink       cfg_we (no wait)        cfg_index, cfg_data
//
// one word per cycle in and out while out_ready keeps the pipeline moving
// the divider has sixteen stages (four quotient bits per stage)
// loads write the side stores at acceptance and give no word
// each stage advances when empty or when the one after it advances, so bubbles close up
// reset clears valid bits and config; store contents stay unknown until loaded
`include "coons_patch_pole_grid_unit_defines.svh"
module coons_patch_pole_grid_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [cppg_pkg::SIDE_W-1:0]         side,
  input  cppg_pkg::idx_t                      side_index,
  input  cppg_pkg::coord_t                    in_x,
  input  cppg_pkg::coord_t                    in_y,
  input  cppg_pkg::coord_t                    in_z,
  input  cppg_pkg::wgt_t                      in_weight,
  input  cppg_pkg::idx_t                      grid_u,
  input  cppg_pkg::idx_t                      grid_v,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cppg_pkg::coord_t                    pole_x,
  output cppg_pkg::coord_t                    pole_y,
  output cppg_pkg::coord_t                    pole_z,
  output cppg_pkg::wgt_t                      pole_weight,
  input  logic                                cfg_we,
  input  logic [cppg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cppg_pkg::CFG_W-1:0]          cfg_data
);
  import cppg_pkg::*;

  // size register holds pole count minus one, clamped to the legal range
  function automatic idx_t span_of(logic [CFG_W-1:0] r);
    if (r < CFG_W'(2)) begin
      return idx_t'(1);
    end else if (r > CFG_W'(MAX_POLES)) begin
      return idx_t'(MAX_POLES - 1);
    end else begin
      return idx_t'(r - CFG_W'(1));
    end
  endfunction

  function automatic coord_t sat_coord(logic [NUM_W-1:0] q, logic neg);
    logic [NUM_W-1:0] m;
    logic [NUM_W-1:0] t;
    if (!neg) begin
      m = (q > COORD_POS_MAX) ? COORD_POS_MAX : q;
      return m[COORD_W-1:0];
    end
    m = (q > COORD_NEG_MAX) ? COORD_NEG_MAX : q;
    t = NUM_W'(0) - m;
    return t[COORD_W-1:0];
  endfunction

  function automatic wgt_t sat_wgt(logic [NUM_W-1:0] q);
    logic [NUM_W-1:0] h;
    h = q >> 1;
    return (h > NUM_W'(WGT_MAX)) ? WGT_MAX : h[WGT_W-1:0];
  endfunction

  // config
  idx_t span_u, span_v;
  logic rational;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_u   <= idx_t'(1);
      span_v   <= idx_t'(1);
      rational <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLES_U:  span_u   <= span_of(cfg_data);
        REG_POLES_V:  span_v   <= span_of(cfg_data);
        REG_RATIONAL: rational <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [N_STAGES:1] v;
  logic [N_STAGES:1] en;
  logic              s1_valid;
  logic [BLEND_STAGES-1:0] blend_v;
  logic [DIV_STAGES-1:0]   div_v;

  assign v[1]                                       = s1_valid;
  assign v[1+BLEND_STAGES:2]                        = blend_v;
  assign v[1+BLEND_STAGES+DIV_STAGES:2+BLEND_STAGES] = div_v;
  assign v[N_STAGES]                                = out_valid;

  // a stage may advance if any stage from it to the output is empty, or the output drains
  for (genvar k = 1; k <= N_STAGES; k++) begin : g_en
    assign en[k] = out_ready || !(&v[N_STAGES:k]);
  end

  assign in_ready = en[1];

  // input decode
  logic  accept, load_acc, in_range, is_query;
  idx_t  du_m_i, dv_m_j;
  geom_t geom_next, geom;
  idx_t  rd_a [N_SIDES];
  idx_t  rd_b [N_SIDES];

  assign accept   = in_valid && in_ready;
  assign load_acc = accept && (command == CMD_LOAD);
  assign is_query = command == CMD_QUERY;
  assign in_range = (grid_u <= span_u) && (grid_v <= span_v);
  assign du_m_i   = span_u - grid_u;
  assign dv_m_j   = span_v - grid_v;

  always_comb begin
    geom_next = '0;
    // rows own the corners
    if (grid_v == '0) begin
      geom_next.on_edge   = 1'b1;
      geom_next.edge_side = SIDE_FIRST_ROW;
    end else if (grid_v == span_v) begin
      geom_next.on_edge   = 1'b1;
      geom_next.edge_side = SIDE_LAST_ROW;
    end else if (grid_u == '0) begin
      geom_next.on_edge   = 1'b1;
      geom_next.edge_side = SIDE_FIRST_COL;
    end else if (grid_u == span_u) begin
      geom_next.on_edge   = 1'b1;
      geom_next.edge_side = SIDE_LAST_COL;
    end
    geom_next.rule_k[SIDE_FIRST_ROW]   = COEF_W'(dv_m_j) * COEF_W'(span_u);
    geom_next.rule_k[SIDE_LAST_ROW]    = COEF_W'(grid_v) * COEF_W'(span_u);
    geom_next.rule_k[SIDE_LAST_COL]    = COEF_W'(grid_u) * COEF_W'(span_v);
    geom_next.rule_k[SIDE_FIRST_COL]   = COEF_W'(du_m_i) * COEF_W'(span_v);
    geom_next.corner_k[SIDE_FIRST_ROW] = COEF_W'(du_m_i) * COEF_W'(dv_m_j);
    geom_next.corner_k[SIDE_LAST_COL]  = COEF_W'(grid_u) * COEF_W'(dv_m_j);
    geom_next.corner_k[SIDE_LAST_ROW]  = COEF_W'(grid_u) * COEF_W'(grid_v);
    geom_next.corner_k[SIDE_FIRST_COL] = COEF_W'(du_m_i) * COEF_W'(grid_v);
    geom_next.den                      = COEF_W'(span_u) * COEF_W'(span_v);
  end

  // read addresses: ruled term along the side, corner term at its fixed end
  always_comb begin
    rd_a[SIDE_FIRST_ROW] = grid_u;
    rd_a[SIDE_LAST_ROW]  = grid_u;
    rd_a[SIDE_LAST_COL]  = grid_v;
    rd_a[SIDE_FIRST_COL] = grid_v;
    rd_b[SIDE_FIRST_ROW] = '0;
    rd_b[SIDE_LAST_COL]  = '0;
    rd_b[SIDE_LAST_ROW]  = span_u;
    rd_b[SIDE_FIRST_COL] = span_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en[1]) begin
      s1_valid <= in_valid && is_query && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      geom <= geom_next;
    end
  end

  // one store per side, read at the ruled and the corner position together
  pole_t [N_SIDES-1:0] pa, pb;
  pole_t               wr_pole;

  assign wr_pole = '{x: in_x, y: in_y, z: in_z, w: in_weight};

  for (genvar s = 0; s < N_SIDES; s++) begin : g_side
    cppg_ram #(
      .WIDTH ($bits(pole_t)),
      .DEPTH (MAX_POLES)
    ) u_store (
      .clk     (clk),
      .we      (load_acc && (side == SIDE_W'(s))),
      .waddr   (side_index),
      .wdata   (wr_pole),
      .rd_en   (en[1]),
      .raddr_a (rd_a[s]),
      .raddr_b (rd_b[s]),
      .rdata_a (pa[s]),
      .rdata_b (pb[s])
    );
  end

  // blend and divide
  div_word_t blend_out, div_out;

  cppg_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en[1+BLEND_STAGES:2]),
    .din_valid (s1_valid),
    .geom      (geom),
    .pa        (pa),
    .pb        (pb),
    .vout      (blend_v),
    .dout      (blend_out)
  );

  cppg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en[1+BLEND_STAGES+DIV_STAGES:2+BLEND_STAGES]),
    .din_valid (blend_v[BLEND_STAGES-1]),
    .din       (blend_out),
    .vout      (div_v),
    .dout      (div_out)
  );

  // output register: edge pole straight through, interior saturated; weight one when not rational
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[N_STAGES]) begin
      out_valid <= div_v[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[N_STAGES]) begin
      if (div_out.on_edge) begin
        pole_x <= div_out.edge_pole.x;
        pole_y <= div_out.edge_pole.y;
        pole_z <= div_out.edge_pole.z;
      end else begin
        pole_x <= sat_coord(div_out.work[LANE_X], div_out.neg[LANE_X]);
        pole_y <= sat_coord(div_out.work[LANE_Y], div_out.neg[LANE_Y]);
        pole_z <= sat_coord(div_out.work[LANE_Z], div_out.neg[LANE_Z]);
      end
      if (!rational) begin
        pole_weight <= WGT_ONE;
      end else if (div_out.on_edge) begin
        pole_weight <= div_out.edge_pole.w;
      end else begin
        pole_weight <= sat_wgt(div_out.work[LANE_W]);
      end
    end
  end

  // checks
  `CPPG_ASSERT_NOW(a_stall_only_when_full, clk, rst, !in_ready, (&v) && !out_ready)
  `CPPG_ASSERT_NEXT(a_load_gives_no_word, clk, rst, load_acc, !s1_valid)
  `CPPG_ASSERT_NOW(a_divisor_nonzero, clk, rst, s1_valid, geom.den != '0)

endmodule

[dv/coons_patch_pole_grid_unit_tb.sv]
// testbench for the coons pole grid unit: directed and random load/query traffic
// predicts every pole word with its own model of the grid blend; needs cppg_pkg and the rtl
module coons_patch_pole_grid_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cppg_pkg::*;

  localparam int STORE_DEPTH = N_SIDES * MAX_POLES;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 40;   // more than the pipeline depth

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic command = CMD_LOAD;
  logic [SIDE_W-1:0] side = SIDE_FIRST_ROW;
  idx_t side_index = '0, grid_u = '0, grid_v = '0;
  coord_t in_x = '0, in_y = '0, in_z = '0;
  wgt_t in_weight = '0;
  logic out_valid, out_ready = 1'b0;
  coord_t pole_x, pole_y, pole_z;
  wgt_t pole_weight;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_POLES_U;
  logic [CFG_W-1:0] cfg_data = '0;

  coons_patch_pole_grid_unit dut (.*);

  always #2 clk = ~clk;

  // our own copy of the side stores and the config registers
  longint side_x[STORE_DEPTH], side_y[STORE_DEPTH], side_z[STORE_DEPTH];
  longint side_w[STORE_DEPTH];
  int grid_nu = 2, grid_nv = 2;
  bit rational = 1'b0;

  pole_t pending_poles[$];
  int errors = 0;
  bit calm = 1'b0;          // when set neither side idles
  int quiet_cycles = 0;

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 28);
  endfunction

  function automatic int clamp_size(int r);
    if (r < 2) return 2;
    if (r > MAX_POLES) return MAX_POLES;
    return r;
  endfunction

  function automatic longint store_read(int lane, int e);
    case (lane)
      LANE_X: return side_x[e];
      LANE_Y: return side_y[e];
      default: return side_z[e];
    endcase
  endfunction

  // exact blend over du*dv, rounded half away from zero, then saturated
  function automatic coord_t coons_coord(int lane, int i, int j);
    longint du, dv, s, mag, q, d;
    du = grid_nu - 1;
    dv = grid_nv - 1;
    s = (dv - j) * du * store_read(lane, i)
      + j * du * store_read(lane, 2 * MAX_POLES + i)
      + i * dv * store_read(lane, MAX_POLES + j)
      + (du - i) * dv * store_read(lane, 3 * MAX_POLES + j)
      - ((du - i) * (dv - j) * store_read(lane, 0)
         + i * (dv - j) * store_read(lane, MAX_POLES)
         + i * j * store_read(lane, 2 * MAX_POLES + int'(du))
         + (du - i) * j * store_read(lane, 3 * MAX_POLES + int'(dv)));
    d = du * dv;
    mag = (s < 0) ? -s : s;
    q = (mag + d / 2) / d;
    if (s >= 0) return (q > 64'sh7FFF_FFFF_FFFF) ? coord_t'(64'sh7FFF_FFFF_FFFF) : coord_t'(q);
    if (q > 64'sh8000_0000_0000) q = 64'sh8000_0000_0000;
    return coord_t'(-q);
  endfunction

  // returns 0 when the position lies outside the grid
  function automatic bit grid_pole(int i, int j, output pole_t p);
    int k;
    longint du, dv, s, q;
    k = -1;
    if (i >= grid_nu || j >= grid_nv) return 1'b0;
    if (j == 0) k = i;
    else if (j == grid_nv - 1) k = 2 * MAX_POLES + i;
    else if (i == 0) k = 3 * MAX_POLES + j;
    else if (i == grid_nu - 1) k = MAX_POLES + j;
    if (k >= 0) begin
      p.x = coord_t'(side_x[k]);
      p.y = coord_t'(side_y[k]);
      p.z = coord_t'(side_z[k]);
      p.w = rational ? wgt_t'(side_w[k]) : WGT_ONE;
      return 1'b1;
    end
    p.x = coons_coord(LANE_X, i, j);
    p.y = coons_coord(LANE_Y, i, j);
    p.z = coons_coord(LANE_Z, i, j);
    if (rational) begin
      du = grid_nu - 1;
      dv = grid_nv - 1;
      // ruled weight sum only, halved, ties up
      s = (dv - j) * du * side_w[i] + j * du * side_w[2 * MAX_POLES + i]
        + i * dv * side_w[MAX_POLES + j] + (du - i) * dv * side_w[3 * MAX_POLES + j];
      q = (s + du * dv) / (2 * du * dv);
      p.w = (q > 64'hFFFF_FFFF) ? WGT_MAX : wgt_t'(q);
    end else begin
      p.w = WGT_ONE;
    end
    return 1'b1;
  endfunction

  // one word on the input channel; the model is updated at acceptance
  task automatic send_word(logic cmd, logic [SIDE_W-1:0] sd, idx_t si, coord_t x, coord_t y,
                           coord_t z, wgt_t w, idx_t u, idx_t v);
    pole_t p;
    int e;
    while (idle_now()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd; side = sd; side_index = si;
    in_x = x; in_y = y; in_z = z; in_weight = w;
    grid_u = u; grid_v = v;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (cmd == CMD_LOAD) begin
      e = sd * MAX_POLES + si;
      side_x[e] = x; side_y[e] = y; side_z[e] = z; side_w[e] = w;
    end else if (grid_pole(u, v, p)) begin
      pending_poles.push_back(p);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic load_pole(logic [SIDE_W-1:0] sd, int si, coord_t x, coord_t y, coord_t z,
                           wgt_t w);
    send_word(CMD_LOAD, sd, idx_t'(si), x, y, z, w, idx_t'($urandom), idx_t'($urandom));
  endtask

  task automatic query_pole(int u, int v);
    send_word(CMD_QUERY, SIDE_W'($urandom), idx_t'($urandom), coord_t'({$urandom, $urandom}),
              coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}),
              wgt_t'($urandom), idx_t'(u), idx_t'(v));
  endtask

  // wait for every pole word, then for any query that gives no word to leave
  task automatic drain();
    wait (pending_poles.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_POLES_U: grid_nu = clamp_size(val & 8'h7F);
      REG_POLES_V: grid_nv = clamp_size(val & 8'h7F);
      default:     rational = val[0];
    endcase
  endtask

  task automatic set_grid(int nu, int nv, bit rat);
    write_reg(REG_POLES_U, nu);
    write_reg(REG_POLES_V, nv);
    write_reg(REG_RATIONAL, int'(rat));
  endtask

  // coordinate biased towards the extremes
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(48'h7FFF_FFFF_FFFF);
      1: return coord_t'(48'h8000_0000_0000);
      2: return '0;
      3: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< FRAC_BITS;
      default: return coord_t'({$urandom, $urandom});
    endcase
  endfunction

  function automatic wgt_t pick_weight();
    case ($urandom_range(0, 5))
      0: return WGT_MAX;
      1: return '0;
      2: return WGT_ONE;
      default: return wgt_t'($urandom);
    endcase
  endfunction

  // every store entry gets a value, so no query ever reads an unloaded entry
  task automatic test_fill_stores();
    for (int sd = 0; sd < N_SIDES; sd++)
      for (int si = 0; si < MAX_POLES; si++)
        load_pole(SIDE_W'(sd), si, pick_coord(), pick_coord(), pick_coord(), pick_weight());
  endtask

  // reset grid, corner ownership, interior blend, saturation both ways, rational weights
  task automatic test_directed();
    query_pole(0, 0);
    query_pole(1, 1);
    query_pole(2, 0);                         // outside the grid, no word
    set_grid(3, 3, 1'b1);
    for (int k = 0; k < 3; k++) begin
      load_pole(SIDE_FIRST_ROW, k, coord_t'(48'h7FFF_FFFF_FFFF), '0, coord_t'(48'h8000_0000_0000),
                WGT_MAX);
      load_pole(SIDE_LAST_ROW, k, coord_t'(48'h7FFF_FFFF_FFFF), '0, coord_t'(48'h8000_0000_0000),
                WGT_MAX);
      load_pole(SIDE_LAST_COL, k, coord_t'(48'h7FFF_FFFF_FFFF), '0, coord_t'(48'h8000_0000_0000),
                WGT_MAX);
      load_pole(SIDE_FIRST_COL, k, coord_t'(48'h7FFF_FFFF_FFFF), '0,
                coord_t'(48'h8000_0000_0000), WGT_MAX);
    end
    // first-row corner pulled to the opposite extreme so the blend overflows
    load_pole(SIDE_FIRST_ROW, 0, coord_t'(48'h8000_0000_0000), '0, coord_t'(48'h7FFF_FFFF_FFFF),
              '0);
    query_pole(1, 1);
    query_pole(0, 0);
    query_pole(2, 2);
    query_pole(0, 1);
    query_pole(2, 1);
    query_pole(1, 3);
    set_grid(0, 127, 1'b0);                  // sizes clamp to 2 and 64
    query_pole(1, 63);
    query_pole(0, 30);
    query_pole(1, 30);
  endtask

  task automatic test_random_grids(int phases);
    int nu, nv, n;
    for (int ph = 0; ph < phases; ph++) begin
      nu = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 8);
      nv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 8);
      if (ph == 1) begin nu = 64; nv = 64; end
      if (ph == 2) begin nu = 2; nv = 2; end
      set_grid(nu, nv, 1'($urandom_range(0, 1)));
      calm = (ph == 3);
      n = 190;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 25)
          load_pole(SIDE_W'($urandom), $urandom_range(0, 63), pick_coord(), pick_coord(),
                    pick_coord(), pick_weight());
        else if ($urandom_range(0, 9) == 0)
          query_pole($urandom_range(0, 63), $urandom_range(0, 63));
        else
          query_pole($urandom_range(0, grid_nu - 1), $urandom_range(0, grid_nv - 1));
        if (k == n / 2 && ph == 4) drain();   // sender holds off until all words are back
      end
      calm = 1'b0;
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) out_ready <= rst ? 1'b0 : !idle_now();

  // compare each pole word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_poles.size() == 0) begin
        $error("pole word with nothing expected");
        errors++;
      end else begin
        pole_t p;
        p = pending_poles.pop_front();
        if (pole_x !== p.x) begin
          $error("pole_x expected %h got %h", p.x, pole_x); errors++;
        end
        if (pole_y !== p.y) begin
          $error("pole_y expected %h got %h", p.y, pole_y); errors++;
        end
        if (pole_z !== p.z) begin
          $error("pole_z expected %h got %h", p.z, pole_z); errors++;
        end
        if (pole_weight !== p.w) begin
          $error("pole_weight expected %h got %h", p.w, pole_weight); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_fill_stores();
    test_directed();
    test_random_grids(9);
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cppg_pkg.sv
rtl/cppg_ram.sv
rtl/cppg_blend.sv
rtl/cppg_divider.sv
rtl/coons_patch_pole_grid_unit.sv
dv/coons_patch_pole_grid_unit_tb.sv
